// ===== design/irt_pkg.sv =====
package irt_pkg;

   // action codes carried in the request word
   localparam logic [1:0] ACT_FIND    = 2'd0;
   localparam logic [1:0] ACT_RESERVE = 2'd1;
   localparam logic [1:0] ACT_QUERY   = 2'd2;
   localparam logic [1:0] ACT_CLEAR   = 2'd3;

   // request word
   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  worker_index;
      logic [23:0] time_value;
      logic        use_now;
      logic [23:0] now_time;
      logic [23:0] duration;
      logic [7:0]  task_tag;
   } req_word_type;

   // response word
   typedef struct packed {
      logic        ok;
      logic [23:0] span_start;
      logic [23:0] span_end;
      logic        end_open;
      logic [7:0]  found_task;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_all;
      logic find_empty;
      logic init_write;
      logic scan_start;
      logic scan_run;
      logic shift_start;
      logic shift_run;
      logic write_a;
      logic write_b;
      logic commit;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] act;
      logic       bad;
      logic       cnt_zero;
      logic       ovf;
      logic       hit;
      logic       scan_end;
      logic       full;
      logic       need_zero;
      logic       move_zero;
      logic       need_b;
      logic       shift_done;
   } dp_status_type;

endpackage

// ===== design/interval_reservation_timeline_core.sv =====
// Per-worker reservation timeline. Each worker keeps a sorted list of boundaries
// (start time plus task tag, tag 0 = free) in one shared boundary memory with one
// read port and one write port; one request word does find, reserve, query or
// clear and returns one response word. Find and query scan the worker's list
// through the memory read port at one boundary per cycle. Reserve scans the same
// way, then moves the boundaries behind the chosen span up one or two places with
// one read and one write per cycle and writes the new boundaries. Requests are
// taken one at a time; a finished response waits in an output register, and a new
// request is taken while it waits. Empty lists are tracked by per-worker counts,
// so no clearing pass runs after reset.
module interval_reservation_timeline_core #(
   parameter int WORKERS            = 16,
   parameter int ENTRIES_PER_WORKER = 32,
   parameter int TIME_BITS          = 24,
   parameter int TASK_BITS          = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  irt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output irt_pkg::rsp_word_type rsp_word
);

   irt_pkg::dp_cmd_type    cmd;
   irt_pkg::dp_status_type status;

   irt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   irt_datapath #(
      .WORKERS            (WORKERS),
      .ENTRIES_PER_WORKER (ENTRIES_PER_WORKER),
      .TIME_BITS          (TIME_BITS),
      .TASK_BITS          (TASK_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

// ===== design/irt_ctrl.sv =====
module irt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  irt_pkg::dp_status_type status,
   output irt_pkg::dp_cmd_type   cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECODE = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_RESV   = 8'b0000_1000,
      ST_SHIFT  = 8'b0001_0000,
      ST_WR_A   = 8'b0010_0000,
      ST_WR_B   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (status.act == irt_pkg::ACT_CLEAR) begin
               cmd.clear_all = 1'b1;
               state_in      = ST_DONE;
            end else if (status.bad) begin
               state_in = ST_DONE;
            end else if (status.act == irt_pkg::ACT_FIND && status.cnt_zero) begin
               cmd.find_empty = 1'b1;
               state_in       = ST_DONE;
            end else if (status.act == irt_pkg::ACT_RESERVE) begin
               cmd.init_write = status.cnt_zero;
               if (status.ovf) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (status.hit) begin
               state_in = (status.act == irt_pkg::ACT_RESERVE) ? ST_RESV : ST_DONE;
            end else if (status.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_RESV: begin
            priority if (status.full) begin
               state_in = ST_DONE;
            end else if (!status.need_zero && !status.move_zero) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end else begin
               state_in = ST_WR_A;
            end
         end
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (status.shift_done) begin
               state_in = ST_WR_A;
            end
         end
         ST_WR_A: begin
            cmd.write_a = 1'b1;
            if (status.need_b) begin
               state_in = ST_WR_B;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_WR_B: begin
            cmd.write_b = 1'b1;
            cmd.commit  = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/irt_datapath.sv =====
module irt_datapath #(
   parameter int WORKERS            = 16,
   parameter int ENTRIES_PER_WORKER = 32,
   parameter int TIME_BITS          = 24,
   parameter int TASK_BITS          = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  irt_pkg::req_word_type  req_word,
   input  irt_pkg::dp_cmd_type    cmd,
   output irt_pkg::dp_status_type status,
   output irt_pkg::rsp_word_type  rsp_word
);

   localparam int IDX_BITS  = $clog2(ENTRIES_PER_WORKER);
   localparam int CNT_BITS  = $clog2(ENTRIES_PER_WORKER + 1);
   localparam int WIDX_BITS = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int DEPTH     = WORKERS * ENTRIES_PER_WORKER;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int WORD_BITS = TIME_BITS + TASK_BITS;

   // boundary memory and per-worker counts
   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [CNT_BITS-1:0]  cnt_ff [WORKERS];

   // captured item
   logic [1:0]           act_ff;
   logic [WIDX_BITS-1:0] widx_ff;
   logic                 inrange_ff;
   logic [TIME_BITS-1:0] tv_ff, now_ff, earliest_ff, en_ff;
   logic                 ovf_ff;
   logic [23:0]          dur_ff;
   logic [TASK_BITS-1:0] tag_ff;

   // scan state
   logic [CNT_BITS-1:0]  issue_ff;
   logic                 rvld_ff, hit_ff, end_ff, pend_valid_ff;
   logic [IDX_BITS-1:0]  rd_idx_ff, pend_idx_ff, hit_idx_ff;
   logic [TIME_BITS-1:0] pend_time_ff, hit_st_ff;
   logic [TASK_BITS-1:0] pend_task_ff;
   logic [WORD_BITS-1:0] rdata_ff;

   // shift state
   logic [IDX_BITS-1:0]  sj_ff, swidx_ff;
   logic [CNT_BITS-1:0]  sleft_ff;
   logic                 svld_ff;

   irt_pkg::rsp_word_type res_ff, rsp_ff;

   // input conditioning
   logic [31:0]          tv_ext, now_ext;
   logic [15:0]          tag_ext;
   logic [8:0]           w_ext;
   logic [TIME_BITS-1:0] tv_in, now_in;
   logic [32:0]          en_sum;

   assign tv_ext  = {8'd0, req_word.time_value};
   assign now_ext = {8'd0, req_word.now_time};
   assign tag_ext = {8'd0, req_word.task_tag};
   assign w_ext   = {5'd0, req_word.worker_index};
   assign tv_in   = tv_ext[TIME_BITS-1:0];
   assign now_in  = now_ext[TIME_BITS-1:0];
   assign en_sum  = 33'(tv_in) + 33'(req_word.duration);

   // current worker
   logic [ADDR_BITS-1:0] base_addr;
   logic [CNT_BITS-1:0]  cnt_cur;

   assign base_addr = ADDR_BITS'(widx_ff) * ADDR_BITS'(ENTRIES_PER_WORKER);
   assign cnt_cur   = cnt_ff[widx_ff];

   // memory read data fields
   logic [TIME_BITS-1:0] rd_time;
   logic [TASK_BITS-1:0] rd_task;

   assign rd_time = rdata_ff[WORD_BITS-1:TASK_BITS];
   assign rd_task = rdata_ff[TASK_BITS-1:0];

   // scan control
   logic scan_active, issuing, ev, open_end;

   assign scan_active = cmd.scan_run && !hit_ff && !end_ff;
   assign issuing     = scan_active && (issue_ff < cnt_cur);
   assign ev          = scan_active && pend_valid_ff;
   assign open_end    = !rvld_ff;

   // test the pending entry against the next boundary
   logic [TIME_BITS-1:0] stc, diff;
   logic                 find_hit, resv_hit, query_hit, eval_hit;

   always_comb begin
      stc       = (pend_time_ff < earliest_ff) ? earliest_ff : pend_time_ff;
      diff      = rd_time - stc;
      find_hit  = (pend_task_ff == '0) &&
                  (open_end || (rd_time >= stc && 33'(diff) >= 33'(dur_ff)));
      resv_hit  = (pend_task_ff == '0) && (tv_ff >= pend_time_ff) &&
                  (open_end || en_ff < rd_time);
      query_hit = (pend_time_ff <= tv_ff) && (open_end || tv_ff < rd_time);
      unique case (act_ff)
         irt_pkg::ACT_FIND:    eval_hit = find_hit;
         irt_pkg::ACT_RESERVE: eval_hit = resv_hit;
         irt_pkg::ACT_QUERY:   eval_hit = query_hit;
         default:              eval_hit = 1'b0;
      endcase
   end

   // reservation sizing
   logic                need_a, need_b;
   logic [1:0]          need;
   logic [9:0]          cnt_need;
   logic [CNT_BITS-1:0] move_cnt, last_idx, dst, idx_a, idx_b;

   always_comb begin
      need_a   = (tv_ff != hit_st_ff);
      need_b   = (dur_ff != 24'd0);
      need     = {1'b0, need_a} + {1'b0, need_b};
      cnt_need = 10'(cnt_cur) + 10'(need);
      move_cnt = cnt_cur - CNT_BITS'(1) - CNT_BITS'(hit_idx_ff);
      last_idx = cnt_cur - CNT_BITS'(1);
      dst      = CNT_BITS'(sj_ff) + CNT_BITS'(need);
      idx_a    = CNT_BITS'(hit_idx_ff) + CNT_BITS'(need_a);
      idx_b    = idx_a + CNT_BITS'(1);
   end

   // status toward the controller
   logic tag_zero;

   assign tag_zero = (tag_ff == '0);

   always_comb begin
      status.act        = act_ff;
      status.bad        = !inrange_ff ||
                          (act_ff == irt_pkg::ACT_FIND && (tag_zero || earliest_ff < now_ff)) ||
                          (act_ff == irt_pkg::ACT_RESERVE && (tag_zero || tv_ff < now_ff));
      status.cnt_zero   = (cnt_cur == '0);
      status.ovf        = ovf_ff;
      status.hit        = hit_ff;
      status.scan_end   = end_ff;
      status.full       = cnt_need > 10'(ENTRIES_PER_WORKER);
      status.need_zero  = (need == 2'd0);
      status.move_zero  = (move_cnt == '0);
      status.need_b     = need_b;
      status.shift_done = (sleft_ff == '0) && !svld_ff;
   end

   // memory port selection
   logic                 shift_issue, rd_en, wr_en;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   assign shift_issue = cmd.shift_run && (sleft_ff != '0);

   always_comb begin
      rd_en   = issuing || shift_issue;
      rd_addr = shift_issue ? base_addr + ADDR_BITS'(sj_ff)
                            : base_addr + ADDR_BITS'(issue_ff[IDX_BITS-1:0]);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base_addr;
      wr_data = {now_ff, {TASK_BITS{1'b0}}};
      priority if (cmd.init_write) begin
         wr_en = 1'b1;
      end else if (cmd.shift_run && svld_ff) begin
         wr_en   = 1'b1;
         wr_addr = base_addr + ADDR_BITS'(swidx_ff);
         wr_data = rdata_ff;
      end else if (cmd.write_a) begin
         wr_en   = 1'b1;
         wr_addr = base_addr + ADDR_BITS'(idx_a[IDX_BITS-1:0]);
         wr_data = {(need_a ? tv_ff : hit_st_ff), tag_ff};
      end else if (cmd.write_b) begin
         wr_en   = 1'b1;
         wr_addr = base_addr + ADDR_BITS'(idx_b[IDX_BITS-1:0]);
         wr_data = {en_ff, {TASK_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // per-worker counts
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         for (int w = 0; w < WORKERS; w++) begin
            cnt_ff[w] <= '0;
         end
      end else if (cmd.init_write) begin
         cnt_ff[widx_ff] <= CNT_BITS'(1);
      end else if (cmd.commit) begin
         cnt_ff[widx_ff] <= cnt_cur + CNT_BITS'(need);
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff      <= req_word.action;
         widx_ff     <= w_ext[WIDX_BITS-1:0];
         inrange_ff  <= (w_ext < 9'(WORKERS));
         tv_ff       <= tv_in;
         now_ff      <= now_in;
         earliest_ff <= req_word.use_now ? now_in : tv_in;
         en_ff       <= en_sum[TIME_BITS-1:0];
         ovf_ff      <= |en_sum[32:TIME_BITS];
         dur_ff      <= req_word.duration;
         tag_ff      <= tag_ext[TASK_BITS-1:0];
      end
   end

   // scan and shift control
   always_ff @(posedge clock) begin
      if (reset) begin
         rvld_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         svld_ff       <= 1'b0;
         sleft_ff      <= '0;
         issue_ff      <= '0;
      end else if (cmd.scan_start) begin
         rvld_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         end_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         issue_ff      <= '0;
      end else if (cmd.shift_start) begin
         sleft_ff <= move_cnt;
         sj_ff    <= last_idx[IDX_BITS-1:0];
         svld_ff  <= 1'b0;
      end else begin
         rvld_ff <= issuing;
         if (issuing) begin
            issue_ff  <= issue_ff + CNT_BITS'(1);
            rd_idx_ff <= issue_ff[IDX_BITS-1:0];
         end
         if (ev && eval_hit) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= pend_idx_ff;
            hit_st_ff  <= pend_time_ff;
         end else if (scan_active && !issuing && !rvld_ff) begin
            end_ff <= 1'b1;
         end
         if (scan_active && rvld_ff) begin
            pend_valid_ff <= 1'b1;
            pend_time_ff  <= rd_time;
            pend_task_ff  <= rd_task;
            pend_idx_ff   <= rd_idx_ff;
         end
         svld_ff <= shift_issue;
         if (shift_issue) begin
            sleft_ff <= sleft_ff - CNT_BITS'(1);
            sj_ff    <= sj_ff - IDX_BITS'(1);
            swidx_ff <= dst[IDX_BITS-1:0];
         end
      end
   end

   // result assembly
   logic [31:0] stc_ext, nxt_ext, earliest_ext;
   logic [15:0] ptask_ext;

   assign stc_ext      = 32'(stc);
   assign nxt_ext      = 32'(rd_time);
   assign earliest_ext = 32'(earliest_ff);
   assign ptask_ext    = 16'(pend_task_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= '0;
      end else if (cmd.find_empty) begin
         res_ff.ok         <= 1'b1;
         res_ff.span_start <= earliest_ext[23:0];
         res_ff.end_open   <= 1'b1;
      end else if (cmd.commit) begin
         res_ff.ok <= 1'b1;
      end else if (ev && eval_hit) begin
         if (act_ff == irt_pkg::ACT_FIND) begin
            res_ff.ok         <= 1'b1;
            res_ff.span_start <= stc_ext[23:0];
            res_ff.span_end   <= open_end ? 24'd0 : nxt_ext[23:0];
            res_ff.end_open   <= open_end;
         end else if (act_ff == irt_pkg::ACT_QUERY) begin
            res_ff.ok         <= (pend_task_ff != '0);
            res_ff.found_task <= ptask_ext[7:0];
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== verif/interval_reservation_timeline_core_tb.sv =====
module interval_reservation_timeline_core_tb;

   localparam int NWORK = 16;
   localparam int NENT  = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   irt_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   irt_pkg::rsp_word_type rsp_word;

   interval_reservation_timeline_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always #1 clock = ~clock;

   // shadow timeline
   logic [23:0] tl_time [NWORK][NENT];
   logic [7:0]  tl_tag  [NWORK][NENT];
   int          tl_count [NWORK];

   irt_pkg::rsp_word_type pending_rsp [$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  idle_enable = 1'b1;
   bit  hold_request = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;
   logic [23:0] now_frame = 24'd0;

   // insert one boundary at pos, shifting the tail up
   function automatic void tl_insert(int w, int pos, logic [23:0] t, logic [7:0] tag);
      for (int k = tl_count[w]; k > pos; k--) begin
         tl_time[w][k] = tl_time[w][k-1];
         tl_tag[w][k]  = tl_tag[w][k-1];
      end
      tl_time[w][pos] = t;
      tl_tag[w][pos]  = tag;
      tl_count[w]++;
   endfunction

   // compute the response and update the shadow timeline
   function automatic irt_pkg::rsp_word_type timeline_apply(irt_pkg::req_word_type r);
      irt_pkg::rsp_word_type o;
      int w;
      int cnt;
      logic [23:0] earliest;
      logic [24:0] en;
      logic [23:0] st;
      int need;
      int pos;
      o = '0;
      w = int'(r.worker_index);
      cnt = tl_count[w];
      case (r.action)
         irt_pkg::ACT_CLEAR: begin
            for (int i = 0; i < NWORK; i++) tl_count[i] = 0;
         end
         irt_pkg::ACT_FIND: begin
            earliest = r.use_now ? r.now_time : r.time_value;
            if (r.task_tag == 0 || earliest < r.now_time) return o;
            if (cnt == 0) begin
               o.ok = 1; o.span_start = earliest; o.end_open = 1;
               return o;
            end
            for (int i = 0; i < cnt; i++) begin
               if (tl_tag[w][i] != 0) continue;
               st = tl_time[w][i];
               if (st < earliest) st = earliest;
               if (i + 1 >= cnt) begin
                  o.ok = 1; o.span_start = st; o.end_open = 1;
                  return o;
               end
               if (tl_time[w][i+1] >= st && tl_time[w][i+1] - st >= r.duration) begin
                  o.ok = 1; o.span_start = st; o.span_end = tl_time[w][i+1];
                  return o;
               end
            end
         end
         irt_pkg::ACT_RESERVE: begin
            if (r.task_tag == 0 || r.time_value < r.now_time) return o;
            if (cnt == 0) begin
               tl_time[w][0] = r.now_time; tl_tag[w][0] = 0;
               cnt = 1; tl_count[w] = 1;
            end
            en = {1'b0, r.time_value} + {1'b0, r.duration};
            if (en[24]) return o;
            for (int i = 0; i < cnt; i++) begin
               if (tl_tag[w][i] != 0) continue;
               st = tl_time[w][i];
               if (r.time_value >= st &&
                   (i + 1 >= cnt || en[23:0] < tl_time[w][i+1])) begin
                  need = int'(r.time_value != st) + int'(r.duration != 0);
                  if (cnt + need > NENT) return o;
                  if (r.time_value == st) begin
                     tl_tag[w][i] = r.task_tag; pos = i;
                  end else begin
                     tl_insert(w, i + 1, r.time_value, r.task_tag); pos = i + 1;
                  end
                  if (r.duration != 0) tl_insert(w, pos + 1, en[23:0], 8'd0);
                  o.ok = 1;
                  return o;
               end
            end
         end
         default: begin
            for (int i = 0; i < cnt; i++) begin
               if (tl_time[w][i] <= r.time_value &&
                   (i + 1 >= cnt || r.time_value < tl_time[w][i+1])) begin
                  o.found_task = tl_tag[w][i];
                  o.ok = tl_tag[w][i] != 0;
                  return o;
               end
            end
         end
      endcase
      return o;
   endfunction

   // sender: optional gap with valid low, then hold the word until accepted
   task automatic send_word(irt_pkg::req_word_type r);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      pending_rsp.push_back(timeline_apply(r));
      req_valid <= 1'b1;
      req_word  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic irt_pkg::req_word_type make_word(logic [1:0] act, int w,
                                                       logic [23:0] tv,
                                                       logic [23:0] dur,
                                                       logic [7:0] tag);
      irt_pkg::req_word_type r;
      r = '0;
      r.action = act; r.worker_index = w[3:0]; r.time_value = tv;
      r.now_time = now_frame; r.duration = dur; r.task_tag = tag;
      return r;
   endfunction

   // receiver: random stall bursts, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 300;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(0, 6));
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      irt_pkg::rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing expected");
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_word.ok !== e.ok) begin
               $error("ok exp %0d got %0d", e.ok, rsp_word.ok); fail_count++;
            end
            if (rsp_word.span_start !== e.span_start) begin
               $error("span_start exp %0d got %0d", e.span_start, rsp_word.span_start);
               fail_count++;
            end
            if (rsp_word.span_end !== e.span_end) begin
               $error("span_end exp %0d got %0d", e.span_end, rsp_word.span_end);
               fail_count++;
            end
            if (rsp_word.end_open !== e.end_open) begin
               $error("end_open exp %0d got %0d", e.end_open, rsp_word.end_open);
               fail_count++;
            end
            if (rsp_word.found_task !== e.found_task) begin
               $error("found_task exp %0d got %0d", e.found_task, rsp_word.found_task);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("interval_reservation_timeline_core_tb NOT OK");
         $finish;
      end
   end

   // directed corners: extremes, every action, invalid tags, overflow, full table
   task automatic test_directed();
      now_frame = 24'd100;
      send_word(make_word(irt_pkg::ACT_QUERY, 0, 24'd5, 24'd0, 8'd0));
      send_word(make_word(irt_pkg::ACT_FIND, 0, 24'd200, 24'd10, 8'd1));
      send_word(make_word(irt_pkg::ACT_FIND, 0, 24'd50, 24'd10, 8'd1));
      send_word(make_word(irt_pkg::ACT_FIND, 0, 24'd200, 24'd10, 8'd0));
      send_word(make_word(irt_pkg::ACT_RESERVE, 0, 24'd100, 24'd10, 8'd0));
      send_word(make_word(irt_pkg::ACT_RESERVE, 0, 24'd50, 24'd10, 8'd3));
      send_word(make_word(irt_pkg::ACT_RESERVE, 1, 24'hFFFFF0, 24'h20, 8'd3));
      send_word(make_word(irt_pkg::ACT_RESERVE, 1, 24'd100, 24'd10, 8'hFF));
      send_word(make_word(irt_pkg::ACT_RESERVE, 1, 24'd120, 24'd0, 8'd7));
      send_word(make_word(irt_pkg::ACT_RESERVE, 1, 24'd130, 24'd20, 8'd8));
      send_word(make_word(irt_pkg::ACT_QUERY, 1, 24'd105, 24'd0, 8'd0));
      send_word(make_word(irt_pkg::ACT_QUERY, 1, 24'd115, 24'd0, 8'd0));
      send_word(make_word(irt_pkg::ACT_QUERY, 1, 24'd99, 24'd0, 8'd0));
      send_word(make_word(irt_pkg::ACT_QUERY, 1, 24'hFFFFFF, 24'd0, 8'd0));
      send_word(make_word(irt_pkg::ACT_FIND, 1, 24'd100, 24'd15, 8'd1));
      send_word(make_word(irt_pkg::ACT_FIND, 1, 24'd100, 24'hFFFFFF, 8'd1));
      begin
         irt_pkg::req_word_type r;
         r = make_word(irt_pkg::ACT_FIND, 1, 24'd0, 24'd5, 8'd1);
         r.use_now = 1'b1;
         send_word(r);
      end
      send_word(make_word(irt_pkg::ACT_RESERVE, 15, 24'hFFFFFF, 24'd0, 8'd9));
      for (int i = 0; i < 18; i++)
         send_word(make_word(irt_pkg::ACT_RESERVE, 2, 24'd200 + 24'(i * 10), 24'd5,
                             8'(i + 1)));
      send_word(make_word(irt_pkg::ACT_FIND, 2, 24'd100, 24'd3, 8'd1));
      send_word(make_word(irt_pkg::ACT_CLEAR, 0, 24'd0, 24'd0, 8'd0));
   endtask

   // random mix, reserves most often, with small times and durations
   task automatic test_random(int n, bit with_hold);
      irt_pkg::req_word_type r;
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == n / 2) hold_request = 1'b1;
         if ($urandom_range(0, 49) == 0) now_frame = now_frame + 24'($urandom_range(0, 50));
         r = '0;
         r.now_time = now_frame;
         r.worker_index = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 3));
         case ($urandom_range(0, 99)) inside
            [0:44]: r.action = irt_pkg::ACT_RESERVE;
            [45:69]: r.action = irt_pkg::ACT_FIND;
            [70:97]: r.action = irt_pkg::ACT_QUERY;
            default: r.action = irt_pkg::ACT_CLEAR;
         endcase
         r.time_value = now_frame + 24'($urandom_range(0, 600)) - 24'($urandom_range(0, 20));
         r.duration = 24'($urandom_range(0, 40));
         r.task_tag = 8'($urandom_range(0, 255));
         r.use_now = 1'($urandom);
         if ($urandom_range(0, 39) == 0) begin
            r.time_value = 24'($urandom);
            r.duration = 24'($urandom);
            r.now_time = 24'($urandom);
         end
         send_word(r);
      end
   endtask

   initial begin
      for (int i = 0; i < NWORK; i++) tl_count[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1400, 1'b1);
      idle_enable = 1'b0;
      test_random(500, 1'b0);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("interval_reservation_timeline_core_tb OK");
      else $display("interval_reservation_timeline_core_tb NOT OK");
      $finish;
   end
endmodule
